@@ rtl/cotgp_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// cotgp_pkg : shared constants and helpers
// Angle reduction, CORDIC arctangent table, saturation limits.
// ---------------------------------------------------------------------------
package cotgp_pkg;

    localparam int CORDIC_STEPS = 32;
    localparam int CW           = 34;   // CORDIC x/y/z working width (Q30 + headroom)
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;
    // pi in Q30 = 18000 * PI_QUO + PI_REM
    localparam logic [31:0]          PI_QUO      = 32'd187403;
    localparam logic [25:0]          PI_REM      = 26'd5426;
    localparam logic [26:0]          RECIP_18000 = 27'd122167959; // ceil(2^41 / 18000)
    localparam logic signed [19:0]   OFF_LIMIT   = 20'sd200000;
    localparam logic signed [36:0]   POS_LIMIT   = 37'sd10000000000;

    typedef logic signed [CW-1:0] t_cw;

    function automatic t_cw atan_q30(input logic [4:0] i);
        t_cw r;
        r = '0;
        case (i)
            5'd0:  r = 34'sh03243F6A8;
            5'd1:  r = 34'sh01DAC6705;
            5'd2:  r = 34'sh00FADBAFC;
            5'd3:  r = 34'sh007F56EA6;
            5'd4:  r = 34'sh003FEAB76;
            5'd5:  r = 34'sh001FFD55B;
            5'd6:  r = 34'sh000FFFAAA;
            5'd7:  r = 34'sh0007FFF55;
            5'd8:  r = 34'sh0003FFFEA;
            5'd9:  r = 34'sh0001FFFFD;
            5'd10: r = 34'sh0000FFFFF;
            5'd11: r = 34'sh00007FFFF;
            5'd12: r = 34'sh00003FFFF;
            5'd13: r = 34'sh00001FFFF;
            5'd14: r = 34'sh00000FFFF;
            5'd15: r = 34'sh000007FFF;
            5'd16: r = 34'sh000003FFF;
            5'd17: r = 34'sh000001FFF;
            5'd18: r = 34'sh000000FFF;
            5'd19: r = 34'sh0000007FF;
            5'd20: r = 34'sh0000003FF;
            5'd21: r = 34'sh0000001FF;
            5'd22: r = 34'sh0000000FF;
            5'd23: r = 34'sh00000007F;
            5'd24: r = 34'sh00000003F;
            5'd25: r = 34'sh00000001F;
            5'd26: r = 34'sh00000000F;
            5'd27: r = 34'sh000000008;
            5'd28: r = 34'sh000000004;
            5'd29: r = 34'sh000000002;
            5'd30: r = 34'sh000000001;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/cotgp_sincos.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// cotgp_sincos : pipelined sine/cosine of a centidegree angle
// Stage 0 wraps/folds the angle, stages 1-2 scale to Q30 radians, then one
// CORDIC micro-rotation per stage, then rounding to Q(FRAC) and clamp.
// Advances on i_en.
// ---------------------------------------------------------------------------
module cotgp_sincos #(
    parameter int FRAC = 16
) (
    input  wire                  i_clk,
    input  wire                  i_en,
    input  wire signed [15:0]    i_ang,
    output logic signed [FRAC+1:0] o_sin,
    output logic signed [FRAC+1:0] o_cos
);
    import cotgp_pkg::*;

    localparam int N = CORDIC_STEPS;
    localparam int SH = 30 - FRAC;

    // stage 0: wrap and fold
    logic signed [16:0] a_w, a_f;
    logic               neg_w;
    logic signed [16:0] r_a;
    logic               r_neg0;
    always_comb begin
        a_w = 17'(i_ang);
        if (a_w >= 17'sd18000) a_w = a_w - 17'sd36000;
        if (a_w < -17'sd18000) a_w = a_w + 17'sd36000;
        a_f   = a_w;
        neg_w = 1'b0;
        if (a_w > 17'sd9000) begin
            a_f = 17'sd18000 - a_w; neg_w = 1'b1;
        end else if (a_w < -17'sd9000) begin
            a_f = -17'sd18000 - a_w; neg_w = 1'b1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a    <= a_f;
            r_neg0 <= neg_w;
        end
    end

    // stage 1: |a|*pi_q30 = 18000*|a|*PI_QUO + |a|*PI_REM, so only the
    // small remainder term (plus the rounding half) needs dividing
    logic [14:0] mag;
    logic [31:0] r_whole;
    logic [25:0] r_frac;
    logic        r_sgn1, r_neg1;
    assign mag = r_a[16] ? 15'(-r_a) : 15'(r_a);
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_whole <= 32'(mag) * PI_QUO;
            r_frac  <= 26'(mag) * PI_REM + 26'd9000;
            r_sgn1  <= r_a[16];
            r_neg1  <= r_neg0;
        end
    end

    // stage 2: remainder term / 18000 by reciprocal, exact below 2^26
    logic [52:0] frac_p;
    logic [31:0] q;
    assign frac_p = 53'(r_frac) * 53'(RECIP_18000);
    assign q      = r_whole + 32'(frac_p[52:41]);

    // CORDIC stages
    t_cw r_x [0:N];
    t_cw r_y [0:N];
    t_cw r_z [0:N];
    logic r_ng [0:N];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]  <= CORDIC_GAIN;
            r_y[0]  <= '0;
            r_z[0]  <= r_sgn1 ? -t_cw'(q) : t_cw'(q);
            r_ng[0] <= r_neg1;
        end
    end
    for (genvar g = 0; g < N; g++) begin : g_cd
        t_cw dx, dy;
        assign dx = r_y[g] >>> g;
        assign dy = r_x[g] >>> g;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[g][CW-1]) begin
                    r_x[g+1] <= r_x[g] - dx;
                    r_y[g+1] <= r_y[g] + dy;
                    r_z[g+1] <= r_z[g] - atan_q30(5'(g));
                end else begin
                    r_x[g+1] <= r_x[g] + dx;
                    r_y[g+1] <= r_y[g] - dy;
                    r_z[g+1] <= r_z[g] + atan_q30(5'(g));
                end
                r_ng[g+1] <= r_ng[g];
            end
        end
    end

    // output: round, clamp, sign of cosine
    localparam logic signed [CW-1:0] ONE  = CW'(1) <<< FRAC;
    localparam logic signed [CW-1:0] HALF = CW'(1) <<< (SH - 1);
    t_cw xr, yr, xs, ys;
    always_comb begin
        xr = (r_x[N] + HALF) >>> SH;
        yr = (r_y[N] + HALF) >>> SH;
        xs = xr > ONE ? ONE : (xr < -ONE ? -ONE : xr);
        ys = yr > ONE ? ONE : (yr < -ONE ? -ONE : yr);
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sin <= (FRAC+2)'(ys);
            o_cos <= r_ng[N] ? -(FRAC+2)'(xs) : (FRAC+2)'(xs);
        end
    end
endmodule
`default_nettype wire

@@ rtl/cotgp_rotate.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// cotgp_rotate : matrix build, vector product and position sums
// Stage A: first products; B: second products and entries;
// C: row products; D: row sums, rounding and saturation; E: add drone and saturate.
// Advances on i_en.
// ---------------------------------------------------------------------------
module cotgp_rotate #(
    parameter int FRAC = 16
) (
    input  wire                    i_clk,
    input  wire                    i_en,
    input  wire signed [FRAC+1:0]  i_sy, i_cy, i_sp, i_cp, i_sr, i_cr,
    input  wire signed [17:0]      i_cam_x, i_cam_y, i_cam_z,
    input  wire signed [34:0]      i_de, i_dn,
    output logic signed [18:0]     o_on, o_oe, o_od,
    output logic signed [34:0]     o_te, o_tn
);
    import cotgp_pkg::*;

    localparam int W = FRAC + 2;       // trig word, +-2^FRAC
    localparam int P = 2 * W;
    localparam int RW = W + 1;          // matrix entry, up to ~2*2^FRAC
    localparam int AW = RW + 19 + 2;    // accumulator

    function automatic logic signed [W-1:0] mq(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
        logic signed [P-1:0] p;
        p = P'(a) * P'(b);
        p = (p + (P'(1) <<< (FRAC - 1))) >>> FRAC;
        return W'(p);
    endfunction

    // stage A
    logic signed [W-1:0] r_ysp, r_ysp2, r_r00, r_syc, r_ycr, r_ysr, r_sys, r_r10;
    logic signed [W-1:0] r_r21, r_r22, r_r20, r_sra, r_cra;
    logic signed [18:0]  r_v0a, r_v1a, r_v2a;
    logic signed [34:0]  r_dea, r_dna;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ysp  <= mq(i_cy, i_sp);
            r_ysp2 <= mq(i_sy, i_sp);
            r_r00  <= mq(i_cy, i_cp);
            r_syc  <= mq(i_sy, i_cr);
            r_ycr  <= mq(i_cy, i_cr);
            r_ysr  <= mq(i_cy, i_sr);
            r_sys  <= mq(i_sy, i_sr);
            r_r10  <= mq(i_sy, i_cp);
            r_r21  <= mq(i_cp, i_sr);
            r_r22  <= mq(i_cp, i_cr);
            r_r20  <= -i_sp;
            r_sra  <= i_sr;
            r_cra  <= i_cr;
            r_v0a  <= 19'(i_cam_z);
            r_v1a  <= 19'(i_cam_x);
            r_v2a  <= -19'(i_cam_y);
            r_dea  <= i_de;
            r_dna  <= i_dn;
        end
    end

    // stage B: matrix entries
    logic signed [RW-1:0] r_m [0:8];
    logic signed [18:0]   r_v0b, r_v1b, r_v2b;
    logic signed [34:0]   r_deb, r_dnb;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0] <= RW'(r_r00);
            r_m[1] <= RW'(mq(r_ysp, r_sra)) - RW'(r_syc);
            r_m[2] <= RW'(mq(r_ysp, r_cra)) + RW'(r_sys);
            r_m[3] <= RW'(r_r10);
            r_m[4] <= RW'(mq(r_ysp2, r_sra)) + RW'(r_ycr);
            r_m[5] <= RW'(mq(r_ysp2, r_cra)) - RW'(r_ysr);
            r_m[6] <= RW'(r_r20);
            r_m[7] <= RW'(r_r21);
            r_m[8] <= RW'(r_r22);
            r_v0b <= r_v0a; r_v1b <= r_v1a; r_v2b <= r_v2a;
            r_deb <= r_dea; r_dnb <= r_dna;
        end
    end

    // stage C: nine products
    logic signed [AW-1:0] r_pr [0:8];
    logic signed [34:0]   r_dec, r_dnc;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                case (k % 3)
                    0:       r_pr[k] <= AW'(r_m[k]) * AW'(r_v0b);
                    1:       r_pr[k] <= AW'(r_m[k]) * AW'(r_v1b);
                    default: r_pr[k] <= AW'(r_m[k]) * AW'(r_v2b);
                endcase
            end
            r_dec <= r_deb; r_dnc <= r_dnb;
        end
    end

    // stage D: sums, rounding, saturation
    logic signed [AW-1:0] acc [0:2];
    logic signed [19:0]   sat_o [0:2];
    logic signed [18:0]   r_o [0:2];
    logic signed [34:0]   r_ded, r_dnd;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            acc[k] = (r_pr[3*k] + r_pr[3*k+1] + r_pr[3*k+2]
                      + (AW'(1) <<< (FRAC - 1))) >>> FRAC;
            if (acc[k] > AW'(OFF_LIMIT))       sat_o[k] = OFF_LIMIT;
            else if (acc[k] < -AW'(OFF_LIMIT)) sat_o[k] = -OFF_LIMIT;
            else                               sat_o[k] = 20'(acc[k]);
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) r_o[k] <= 19'(sat_o[k]);
            r_ded <= r_dec; r_dnd <= r_dnc;
        end
    end

    // stage E: position sums
    logic signed [36:0] se, sn;
    assign se = 37'(r_ded) + 37'(r_o[1]);
    assign sn = 37'(r_dnd) + 37'(r_o[0]);
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_on <= r_o[0];
            o_oe <= r_o[1];
            o_od <= r_o[2];
            o_te <= 35'(se > POS_LIMIT ? POS_LIMIT : (se < -POS_LIMIT ? -POS_LIMIT : se));
            o_tn <= 35'(sn > POS_LIMIT ? POS_LIMIT : (sn < -POS_LIMIT ? -POS_LIMIT : sn));
        end
    end
endmodule
`default_nettype wire

@@ rtl/camera_offset_to_ground_position.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// camera_offset_to_ground_position : camera offset to ground frame
// Three CORDIC sin/cos pipelines feed a matrix/vector pipeline.
//
//   channel | handshake          | words
//   in      | i_valid / o_ready  | camera offset, gimbal angles, drone pos
//   out     | o_valid / i_ready  | ground offset, target position
//
// One word per cycle sustained while the output is not stalled; the
// pipeline includes the 32 CORDIC micro-rotation stages.
// The whole pipeline advances together; a stall at the output freezes it.
// Reset clears the valid bits only.
// ---------------------------------------------------------------------------
module camera_offset_to_ground_position #(
    parameter int TRIG_FRAC_BITS = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire signed [17:0]  i_cam_x,
    input  wire signed [17:0]  i_cam_y,
    input  wire signed [17:0]  i_cam_z,
    input  wire signed [15:0]  i_gimbal_yaw,
    input  wire signed [15:0]  i_gimbal_pitch,
    input  wire signed [15:0]  i_gimbal_roll,
    input  wire signed [34:0]  i_drone_east,
    input  wire signed [34:0]  i_drone_north,
    output logic               o_valid,
    input  wire                i_ready,
    output logic signed [18:0] o_offset_north,
    output logic signed [18:0] o_offset_east,
    output logic signed [18:0] o_offset_down,
    output logic signed [34:0] o_target_east,
    output logic signed [34:0] o_target_north
);
    import cotgp_pkg::*;

    localparam int F = TRIG_FRAC_BITS;
    localparam int LT = CORDIC_STEPS + 4;
    localparam int LAT = LT + 5;

    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    logic [LAT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (en)  r_vld <= {r_vld[LAT-2:0], i_valid};
    end
    assign o_valid = r_vld[LAT-1];

    // delay the linear inputs to match the trig latency
    logic signed [17:0] r_cx [0:LT-1];
    logic signed [17:0] r_cy [0:LT-1];
    logic signed [17:0] r_cz [0:LT-1];
    logic signed [34:0] r_de [0:LT-1];
    logic signed [34:0] r_dn [0:LT-1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cx[0] <= i_cam_x; r_cy[0] <= i_cam_y; r_cz[0] <= i_cam_z;
            r_de[0] <= i_drone_east; r_dn[0] <= i_drone_north;
            for (int k = 1; k < LT; k++) begin
                r_cx[k] <= r_cx[k-1]; r_cy[k] <= r_cy[k-1]; r_cz[k] <= r_cz[k-1];
                r_de[k] <= r_de[k-1]; r_dn[k] <= r_dn[k-1];
            end
        end
    end

    logic signed [F+1:0] sy, cy, sp, cp, sr, cr;
    cotgp_sincos #(.FRAC(F)) u_yaw (.i_clk, .i_en(en), .i_ang(i_gimbal_yaw),
                                    .o_sin(sy), .o_cos(cy));
    cotgp_sincos #(.FRAC(F)) u_pit (.i_clk, .i_en(en), .i_ang(i_gimbal_pitch),
                                    .o_sin(sp), .o_cos(cp));
    cotgp_sincos #(.FRAC(F)) u_rol (.i_clk, .i_en(en), .i_ang(i_gimbal_roll),
                                    .o_sin(sr), .o_cos(cr));

    cotgp_rotate #(.FRAC(F)) u_rot (
        .i_clk, .i_en(en),
        .i_sy(sy), .i_cy(cy), .i_sp(sp), .i_cp(cp), .i_sr(sr), .i_cr(cr),
        .i_cam_x(r_cx[LT-1]), .i_cam_y(r_cy[LT-1]), .i_cam_z(r_cz[LT-1]),
        .i_de(r_de[LT-1]), .i_dn(r_dn[LT-1]),
        .o_on(o_offset_north), .o_oe(o_offset_east), .o_od(o_offset_down),
        .o_te(o_target_east), .o_tn(o_target_north)
    );

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_target_east))
        else $error("result changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("ready low with empty output");
    a_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_offset_down <= 19'sd200000 && o_offset_down >= -19'sd200000)
        else $error("offset outside limit");
endmodule
`default_nettype wire

@@ tb/sv/cotgp_checker.sv @@
// ---------------------------------------------------------------------------
// cotgp_checker : ground position predictor and result checker
// Watches both channels, predicts the ground offset and target position
// of every accepted word and compares each result word in order.
// ---------------------------------------------------------------------------
module cotgp_checker #(
    parameter int TRIG_FRAC_BITS = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    input  wire                i_in_ready,
    input  wire signed [17:0]  i_cam_x,
    input  wire signed [17:0]  i_cam_y,
    input  wire signed [17:0]  i_cam_z,
    input  wire signed [15:0]  i_gimbal_yaw,
    input  wire signed [15:0]  i_gimbal_pitch,
    input  wire signed [15:0]  i_gimbal_roll,
    input  wire signed [34:0]  i_drone_east,
    input  wire signed [34:0]  i_drone_north,
    input  wire                i_out_valid,
    input  wire                i_out_ready,
    input  wire signed [18:0]  i_offset_north,
    input  wire signed [18:0]  i_offset_east,
    input  wire signed [18:0]  i_offset_down,
    input  wire signed [34:0]  i_target_east,
    input  wire signed [34:0]  i_target_north,
    output int                 o_errors,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [18:0] off_n;
        logic signed [18:0] off_e;
        logic signed [18:0] off_d;
        logic signed [34:0] tgt_e;
        logic signed [34:0] tgt_n;
    } ground_t;

    localparam int F = TRIG_FRAC_BITS;

    ground_t ground_q[$];
    longint  arctan[32];

    initial begin
        arctan = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                   64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                   64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                   64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
                   64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                   64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
                   64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008,
                   64'h00000004, 64'h00000002, 64'h00000001, 64'h00000000};
    end

    // >>> on longint is arithmetic, i.e. floor
    function automatic longint round_shift(longint v, int s);
        if (s == 0) return v;
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return round_shift(a * b, F);
    endfunction

    function automatic void trig(input longint cd, output longint sn, output longint cs);
        longint a, n, m, z, x, y, dx, dy, one;
        bit flip;
        one = 64'sd1 <<< F;
        flip = 0;
        a = cd % 36000;
        if (a >= 18000) a -= 36000;
        if (a < -18000) a += 36000;
        if (a > 9000) begin
            a = 18000 - a;
            flip = 1;
        end else if (a < -9000) begin
            a = -18000 - a;
            flip = 1;
        end
        n = a * 64'sd3373259426;
        m = (n < 0) ? -n : n;
        m = (m + 9000) / 18000;
        z = (n < 0) ? -m : m;
        x = 64'sh26DD3B6A;
        y = 0;
        for (int i = 0; i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan[i];
            end else begin
                x += dx; y -= dy; z += arctan[i];
            end
        end
        x = clip(round_shift(x, 30 - F), one);
        y = clip(round_shift(y, 30 - F), one);
        sn = y;
        cs = flip ? -x : x;
    endfunction

    function automatic ground_t ground_position(
        longint cx, longint cy, longint cz, longint yaw, longint pit, longint rol,
        longint de, longint dn);
        longint sy, cyw, sp, cp, sr, cr, ysp, ysp2;
        longint r[3][3];
        longint v[3];
        longint off[3];
        ground_t g;
        trig(yaw, sy, cyw);
        trig(pit, sp, cp);
        trig(rol, sr, cr);
        v[0] = cz; v[1] = cx; v[2] = -cy;
        ysp  = qmul(cyw, sp);
        ysp2 = qmul(sy, sp);
        r[0][0] = qmul(cyw, cp);
        r[0][1] = qmul(ysp, sr) - qmul(sy, cr);
        r[0][2] = qmul(ysp, cr) + qmul(sy, sr);
        r[1][0] = qmul(sy, cp);
        r[1][1] = qmul(ysp2, sr) + qmul(cyw, cr);
        r[1][2] = qmul(ysp2, cr) - qmul(cyw, sr);
        r[2][0] = -sp;
        r[2][1] = qmul(cp, sr);
        r[2][2] = qmul(cp, cr);
        for (int i = 0; i < 3; i++)
            off[i] = clip(round_shift(r[i][0] * v[0] + r[i][1] * v[1]
                                      + r[i][2] * v[2], F), 200000);
        g.off_n = 19'(off[0]);
        g.off_e = 19'(off[1]);
        g.off_d = 19'(off[2]);
        g.tgt_e = 35'(clip(de + off[1], 64'sd10000000000));
        g.tgt_n = 35'(clip(dn + off[0], 64'sd10000000000));
        return g;
    endfunction

    initial o_errors = 0;
    assign o_pending = ground_q.size();

    always @(posedge i_clk) begin
        ground_t want;
        if (i_rst_n && i_in_valid && i_in_ready)
            ground_q.push_back(ground_position(i_cam_x, i_cam_y, i_cam_z,
                i_gimbal_yaw, i_gimbal_pitch, i_gimbal_roll,
                i_drone_east, i_drone_north));
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (ground_q.size() == 0) begin
                $display("%0t: result word with none expected", $time);
                o_errors <= o_errors + 1;
            end else begin
                want = ground_q.pop_front();
                if (want.off_n !== i_offset_north || want.off_e !== i_offset_east
                    || want.off_d !== i_offset_down || want.tgt_e !== i_target_east
                    || want.tgt_n !== i_target_north) begin
                    $display("%0t: expected n=%0d e=%0d d=%0d te=%0d tn=%0d", $time,
                             want.off_n, want.off_e, want.off_d, want.tgt_e,
                             want.tgt_n);
                    $display("%0t: actual   n=%0d e=%0d d=%0d te=%0d tn=%0d", $time,
                             i_offset_north, i_offset_east, i_offset_down,
                             i_target_east, i_target_north);
                    o_errors <= o_errors + 1;
                end
            end
        end
    end
endmodule

@@ tb/sv/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top : camera offset to ground position testbench
// Directed angle and range corners, then random words with random gaps
// and output stalls; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_valid = 0;
    logic               i_ready = 0;
    logic               o_ready, o_valid;
    logic signed [17:0] cam_x = 0, cam_y = 0, cam_z = 0;
    logic signed [15:0] yaw = 0, pitch = 0, roll = 0;
    logic signed [34:0] d_east = 0, d_north = 0;
    logic signed [18:0] off_n, off_e, off_d;
    logic signed [34:0] tgt_e, tgt_n;
    int                 errors, pending;
    int                 cycles = 0;
    bit                 calm = 0;

    always #2 i_clk = ~i_clk;

    camera_offset_to_ground_position u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_cam_x(cam_x), .i_cam_y(cam_y), .i_cam_z(cam_z),
        .i_gimbal_yaw(yaw), .i_gimbal_pitch(pitch), .i_gimbal_roll(roll),
        .i_drone_east(d_east), .i_drone_north(d_north),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_offset_north(off_n), .o_offset_east(off_e), .o_offset_down(off_d),
        .o_target_east(tgt_e), .o_target_north(tgt_n));

    cotgp_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_valid), .i_in_ready(o_ready),
        .i_cam_x(cam_x), .i_cam_y(cam_y), .i_cam_z(cam_z),
        .i_gimbal_yaw(yaw), .i_gimbal_pitch(pitch), .i_gimbal_roll(roll),
        .i_drone_east(d_east), .i_drone_north(d_north),
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_offset_north(off_n), .i_offset_east(off_e), .i_offset_down(off_d),
        .i_target_east(tgt_e), .i_target_north(tgt_n),
        .o_errors(errors), .o_pending(pending));

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("[camera_offset_to_ground_position] ERROR");
            $finish;
        end
    end

    // receiver stalls, ~15 %, none during the calm stretch
    always @(posedge i_clk)
        i_ready <= calm || ($urandom_range(99) >= 15);

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(3))
            0: return 16'($urandom);                    // any code, wraps
            1: return $signed(16'($urandom_range(36000))) - 16'sd18000;
            2: return 16'($urandom_range(2)) * 16'sd9000
                      - 16'sd9000 + $signed(16'($urandom_range(4))) - 16'sd2;
            default: return $signed(16'($urandom_range(18000))) - 16'sd9000;
        endcase
    endfunction

    function automatic logic signed [17:0] rand_cam();
        if ($urandom_range(9) == 0) return 18'($urandom);
        return $signed(18'($urandom_range(200000))) - 18'sd100000;
    endfunction

    function automatic logic signed [34:0] rand_pos();
        case ($urandom_range(3))
            0: return 35'({$urandom, $urandom});
            1: return ($urandom_range(1) ? 35'sd10000000000 : -35'sd10000000000)
                      + $signed(35'($urandom_range(400000))) - 35'sd200000;
            default: return $signed(35'($urandom)) - 35'sd2147483648;
        endcase
    endfunction

    task automatic send_word(logic signed [17:0] x, y, z,
                             logic signed [15:0] yw, pt, rl,
                             logic signed [34:0] de, dn);
        while (!calm && $urandom_range(99) < 15) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        cam_x <= x; cam_y <= y; cam_z <= z;
        yaw <= yw; pitch <= pt; roll <= rl;
        d_east <= de; d_north <= dn;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic drop_valid();
        i_valid <= 0;
        @(posedge i_clk);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // corners: zero, range edges, fold points, wrap, saturation
        send_word(0, 0, 0, 0, 0, 0, 0, 0);
        send_word(100000, -100000, 100000, 18000, -18000, 18000,
                  35'sd10000000000, -35'sd10000000000);
        send_word(-100000, 100000, -100000, -18000, 18000, -18000,
                  -35'sd10000000000, 35'sd10000000000);
        send_word(1000, 2000, 3000, 9000, 9001, 8999, 0, 0);
        send_word(1000, 2000, 3000, -9000, -9001, -8999, 5, -5);
        send_word(131071, -131072, 131071, 32767, -32768, 27000, 0, 0);
        send_word(-131072, 131071, -131072, -32768, 32767, -27000,
                  35'sh3FFFFFFFF, 35'sh400000000);
        send_word(131071, 131071, 131071, 4500, 4500, 4500,
                  35'sd10000000000, 35'sd10000000000);
        send_word(-131072, -131072, -131072, -13500, 13500, 0,
                  -35'sd10000000000, -35'sd10000000000);
        send_word(12345, -6789, 54321, 36000, -36000, 1, 123, -456);
        send_word(1, -1, 1, -1, 1, -1, -1, 1);
        drop_valid();

        // hold off until the pipeline has drained
        while (pending != 0) @(posedge i_clk);

        calm = 1;
        repeat (200) send_word(rand_cam(), rand_cam(), rand_cam(), rand_angle(),
                               rand_angle(), rand_angle(), rand_pos(), rand_pos());
        calm = 0;
        repeat (1600) send_word(rand_cam(), rand_cam(), rand_cam(), rand_angle(),
                                rand_angle(), rand_angle(), rand_pos(), rand_pos());
        drop_valid();

        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0)
            $display("[camera_offset_to_ground_position] OK");
        else
            $display("[camera_offset_to_ground_position] ERROR");
        $finish;
    end
endmodule
